FILE: src/calru_pkg.sv
// shared types and constants for the client activity lru table
`timescale 1ns / 1ps

package calru_pkg;

    localparam int PENDING_DEPTH = 256;
    localparam int CLIENT_SLOTS  = 32;
    localparam int ID_BITS       = 16;

    localparam int TAG_W    = 16;
    localparam int METHOD_W = 8;
    localparam int TIME_W   = 48;
    localparam int STAMP_W  = 32;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_NOTE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PSCAN,
        ST_PWRITE,
        ST_CSCAN,
        ST_CWRITE,
        ST_DONE
    } state_t;

endpackage

FILE: src/client_activity_lru_table_core.sv
// client activity lru table: pending request table and client recency table
`timescale 1ns / 1ps

// One beat is handled at a time; s_axis_tready is high only while the sequencer is idle.
// A note scans the pending table, a dispatch the pending and then the client table,
// a query the client table; dispatch and query results may wait for the output register
// to drain, and an empty note or an unused kind is dropped without any scan. Each table
// memory is walked one entry per cycle through its single registered read port, with one
// shared magnitude comparator doing the age, recency and eviction decisions.
module client_activity_lru_table_core #(
    parameter int PENDING_DEPTH = calru_pkg::PENDING_DEPTH,
    parameter int CLIENT_SLOTS  = calru_pkg::CLIENT_SLOTS,
    parameter int ID_BITS       = calru_pkg::ID_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // request_id, client_id, method_id, time_now
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // client_id_out, method_out, age_ticks
    output logic [0:0]  m_axis_tuser    // found
);

    localparam int PW   = $clog2(PENDING_DEPTH);
    localparam int CW   = $clog2(CLIENT_SLOTS);
    localparam int MAXD = (PENDING_DEPTH > CLIENT_SLOTS) ? PENDING_DEPTH : CLIENT_SLOTS;
    localparam int CNTW = $clog2(MAXD + 1);
    localparam int TW   = calru_pkg::TIME_W;
    localparam int MW   = calru_pkg::METHOD_W;
    localparam int SW   = calru_pkg::STAMP_W;

    calru_pkg::state_t state_reg, state_next;

    logic [calru_pkg::KIND_W-1:0] kind_reg;
    logic [ID_BITS-1:0]           req_reg;
    logic [ID_BITS-1:0]           tag_reg;
    logic [MW-1:0]                method_reg;
    logic [TW-1:0]                now_reg;
    logic [CNTW-1:0]              cnt_reg;
    logic [SW-1:0]                ins_cnt_reg;

    logic [PENDING_DEPTH-1:0]     p_valid_reg;
    logic [2*ID_BITS-1:0]         pend_mem [PENDING_DEPTH];
    logic [SW-1:0]                stamp_mem [PENDING_DEPTH];
    logic [2*ID_BITS-1:0]         p_rd_reg;
    logic [SW-1:0]                s_rd_reg;

    logic [CLIENT_SLOTS-1:0]      c_valid_reg;
    logic [ID_BITS-1:0]           key_mem [CLIENT_SLOTS];
    logic [MW-1:0]                meth_mem [CLIENT_SLOTS];
    logic [TW-1:0]                seen_mem [CLIENT_SLOTS];
    logic [ID_BITS-1:0]           ck_rd_reg;
    logic [MW-1:0]                cm_rd_reg;
    logic [TW-1:0]                cs_rd_reg;

    logic          p_hit_reg, p_free_reg, p_old_reg;
    logic [PW-1:0] p_hit_idx_reg, p_free_idx_reg, p_old_idx_reg;
    logic [SW-1:0] p_old_age_reg;
    logic          c_hit_reg, c_free_reg, c_best_reg;
    logic [CW-1:0] c_hit_idx_reg, c_free_idx_reg, c_best_idx_reg;
    logic [TW-1:0] best_val_reg;
    logic [ID_BITS-1:0] best_key_reg;
    logic [MW-1:0] best_meth_reg;

    logic          m_valid_reg, m_found_reg;
    logic [calru_pkg::TAG_W-1:0] m_client_reg;
    logic [MW-1:0] m_method_reg;
    logic [TW-1:0] m_age_reg;

    // input fields and tag resizing
    logic [calru_pkg::TAG_W-1:0] in_req, in_client;
    logic [31:0]        in_req32, in_client32, out_tag32, best_key32;
    logic [ID_BITS-1:0] in_req_tag, in_client_tag;
    logic               accept, empty_note, out_free;

    // scan signals
    logic [CNTW-1:0]    ent;
    logic [PW-1:0]      p_ent;
    logic [CW-1:0]      c_ent;
    logic               scan_live, p_v, c_v;
    logic [ID_BITS-1:0] rd_req, rd_client;
    logic [SW-1:0]      age_cur;
    logic [TW-1:0]      cmp_a, cmp_b;
    logic               cmp_gt;
    logic [PW-1:0]      p_slot;
    logic [CW-1:0]      c_slot;
    logic               pend_we, stamp_we, c_we;

    assign in_req       = s_axis_tdata[15:0];
    assign in_client    = s_axis_tdata[31:16];
    assign in_req32     = 32'(in_req);
    assign in_client32  = 32'(in_client);
    assign in_req_tag   = in_req32[ID_BITS-1:0];
    assign in_client_tag = in_client32[ID_BITS-1:0];
    assign out_tag32    = 32'(tag_reg);
    assign best_key32   = 32'(best_key_reg);

    assign s_axis_tready = (state_reg == calru_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign empty_note    = (in_req_tag == '0) || (in_client_tag == '0);
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign ent       = cnt_reg - CNTW'(1);
    assign p_ent     = ent[PW-1:0];
    assign c_ent     = ent[CW-1:0];
    assign scan_live = (cnt_reg != '0);
    assign p_v       = p_valid_reg[p_ent];
    assign c_v       = c_valid_reg[c_ent];
    assign rd_req    = p_rd_reg[2*ID_BITS-1:ID_BITS];
    assign rd_client = p_rd_reg[ID_BITS-1:0];
    assign age_cur   = ins_cnt_reg - s_rd_reg;

    assign p_slot = p_hit_reg ? p_hit_idx_reg : (p_free_reg ? p_free_idx_reg : p_old_idx_reg);
    assign c_slot = c_hit_reg ? c_hit_idx_reg : (c_free_reg ? c_free_idx_reg : c_best_idx_reg);

    // shared comparator operand selection
    always_comb
    begin
        cmp_a = now_reg;
        cmp_b = best_val_reg;
        case (state_reg)
            calru_pkg::ST_PSCAN:
            begin
                cmp_a = TW'(age_cur);
                cmp_b = TW'(p_old_age_reg);
            end
            calru_pkg::ST_CSCAN:
            begin
                if (kind_reg == calru_pkg::KIND_QUERY)
                begin
                    cmp_a = cs_rd_reg;
                    cmp_b = best_val_reg;
                end
                else
                begin
                    cmp_a = best_val_reg;
                    cmp_b = cs_rd_reg;
                end
            end
            calru_pkg::ST_CWRITE:
            begin
                cmp_a = best_val_reg;
                cmp_b = now_reg;
            end
            default:
            begin
                cmp_a = now_reg;
                cmp_b = best_val_reg;
            end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;

    // next state and write strobes
    always_comb
    begin
        state_next = state_reg;
        pend_we    = 1'b0;
        stamp_we   = 1'b0;
        c_we       = 1'b0;
        case (state_reg)
            calru_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        calru_pkg::KIND_NOTE:
                            state_next = empty_note ? calru_pkg::ST_IDLE : calru_pkg::ST_PSCAN;
                        calru_pkg::KIND_DISPATCH: state_next = calru_pkg::ST_PSCAN;
                        calru_pkg::KIND_QUERY:    state_next = calru_pkg::ST_CSCAN;
                        default:                  state_next = calru_pkg::ST_IDLE;
                    endcase
                end
            end
            calru_pkg::ST_PSCAN:
            begin
                if (cnt_reg == CNTW'(PENDING_DEPTH))
                    state_next = calru_pkg::ST_PWRITE;
            end
            calru_pkg::ST_PWRITE:
            begin
                if (kind_reg == calru_pkg::KIND_NOTE)
                begin
                    pend_we    = 1'b1;
                    stamp_we   = !p_hit_reg;
                    state_next = calru_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = calru_pkg::ST_CSCAN;
                end
            end
            calru_pkg::ST_CSCAN:
            begin
                if (cnt_reg == CNTW'(CLIENT_SLOTS))
                    state_next = (kind_reg == calru_pkg::KIND_QUERY) ?
                                 calru_pkg::ST_DONE : calru_pkg::ST_CWRITE;
            end
            calru_pkg::ST_CWRITE:
            begin
                c_we       = c_hit_reg || c_free_reg || !cmp_gt;
                state_next = calru_pkg::ST_DONE;
            end
            calru_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = calru_pkg::ST_IDLE;
            end
            default: state_next = calru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= calru_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[p_slot] <= {req_reg, tag_reg};
        p_rd_reg <= pend_mem[cnt_reg[PW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
            stamp_mem[p_slot] <= ins_cnt_reg;
        s_rd_reg <= stamp_mem[cnt_reg[PW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            key_mem[c_slot]  <= tag_reg;
            meth_mem[c_slot] <= method_reg;
            seen_mem[c_slot] <= now_reg;
        end
        ck_rd_reg <= key_mem[cnt_reg[CW-1:0]];
        cm_rd_reg <= meth_mem[cnt_reg[CW-1:0]];
        cs_rd_reg <= seen_mem[cnt_reg[CW-1:0]];
    end

    // sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= '0;
            req_reg        <= '0;
            tag_reg        <= '0;
            method_reg     <= '0;
            now_reg        <= '0;
            cnt_reg        <= '0;
            ins_cnt_reg    <= '0;
            p_valid_reg    <= '0;
            c_valid_reg    <= '0;
            p_hit_reg      <= 1'b0;
            p_free_reg     <= 1'b0;
            p_old_reg      <= 1'b0;
            p_hit_idx_reg  <= '0;
            p_free_idx_reg <= '0;
            p_old_idx_reg  <= '0;
            p_old_age_reg  <= '0;
            c_hit_reg      <= 1'b0;
            c_free_reg     <= 1'b0;
            c_best_reg     <= 1'b0;
            c_hit_idx_reg  <= '0;
            c_free_idx_reg <= '0;
            c_best_idx_reg <= '0;
            best_val_reg   <= '0;
            best_key_reg   <= '0;
            best_meth_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_found_reg    <= 1'b0;
            m_client_reg   <= '0;
            m_method_reg   <= '0;
            m_age_reg      <= '0;
        end
        else
        begin
            if ((state_reg == calru_pkg::ST_DONE) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                calru_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg   <= s_axis_tuser;
                        req_reg    <= in_req_tag;
                        tag_reg    <= (s_axis_tuser == calru_pkg::KIND_DISPATCH) ?
                                      '0 : in_client_tag;
                        method_reg <= s_axis_tdata[39:32];
                        now_reg    <= s_axis_tdata[87:40];
                        cnt_reg    <= '0;
                        p_hit_reg  <= 1'b0;
                        p_free_reg <= 1'b0;
                        p_old_reg  <= 1'b0;
                        c_hit_reg  <= 1'b0;
                        c_free_reg <= 1'b0;
                        c_best_reg <= 1'b0;
                    end
                end
                calru_pkg::ST_PSCAN:
                begin
                    if (cnt_reg != CNTW'(PENDING_DEPTH))
                        cnt_reg <= cnt_reg + CNTW'(1);
                    if (scan_live)
                    begin
                        if (p_v && (rd_req == req_reg) && !p_hit_reg)
                        begin
                            p_hit_reg     <= 1'b1;
                            p_hit_idx_reg <= p_ent;
                            if (kind_reg == calru_pkg::KIND_DISPATCH)
                                tag_reg <= rd_client;
                        end
                        if (!p_v && !p_free_reg)
                        begin
                            p_free_reg     <= 1'b1;
                            p_free_idx_reg <= p_ent;
                        end
                        if (p_v && (!p_old_reg || cmp_gt))
                        begin
                            p_old_reg     <= 1'b1;
                            p_old_idx_reg <= p_ent;
                            p_old_age_reg <= age_cur;
                        end
                    end
                end
                calru_pkg::ST_PWRITE:
                begin
                    cnt_reg <= '0;
                    if (kind_reg == calru_pkg::KIND_NOTE)
                    begin
                        p_valid_reg[p_slot] <= 1'b1;
                        if (!p_hit_reg)
                            ins_cnt_reg <= ins_cnt_reg + SW'(1);
                    end
                    else if (p_hit_reg)
                    begin
                        p_valid_reg[p_hit_idx_reg] <= 1'b0;
                    end
                end
                calru_pkg::ST_CSCAN:
                begin
                    if (cnt_reg != CNTW'(CLIENT_SLOTS))
                        cnt_reg <= cnt_reg + CNTW'(1);
                    if (scan_live)
                    begin
                        if (kind_reg == calru_pkg::KIND_QUERY)
                        begin
                            if (c_v && (ck_rd_reg != tag_reg) && (!c_best_reg || cmp_gt))
                            begin
                                c_best_reg     <= 1'b1;
                                c_best_idx_reg <= c_ent;
                                best_val_reg   <= cs_rd_reg;
                                best_key_reg   <= ck_rd_reg;
                                best_meth_reg  <= cm_rd_reg;
                            end
                        end
                        else
                        begin
                            if (c_v && (ck_rd_reg == tag_reg) && !c_hit_reg)
                            begin
                                c_hit_reg     <= 1'b1;
                                c_hit_idx_reg <= c_ent;
                            end
                            if (!c_v && !c_free_reg)
                            begin
                                c_free_reg     <= 1'b1;
                                c_free_idx_reg <= c_ent;
                            end
                            if (c_v && (!c_best_reg || cmp_gt))
                            begin
                                c_best_reg     <= 1'b1;
                                c_best_idx_reg <= c_ent;
                                best_val_reg   <= cs_rd_reg;
                            end
                        end
                    end
                end
                calru_pkg::ST_CWRITE:
                begin
                    if (c_hit_reg || c_free_reg || !cmp_gt)
                        c_valid_reg[c_slot] <= 1'b1;
                end
                calru_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        if (kind_reg == calru_pkg::KIND_QUERY)
                        begin
                            m_found_reg  <= c_best_reg;
                            m_client_reg <= c_best_reg ? best_key32[15:0] : '0;
                            m_method_reg <= c_best_reg ? best_meth_reg : '0;
                            m_age_reg    <= (c_best_reg && cmp_gt) ?
                                            (now_reg - best_val_reg) : '0;
                        end
                        else
                        begin
                            m_found_reg  <= p_hit_reg;
                            m_client_reg <= out_tag32[15:0];
                            m_method_reg <= '0;
                            m_age_reg    <= '0;
                        end
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_age_reg, m_method_reg, m_client_reg};
    assign m_axis_tuser  = m_found_reg;

`ifndef SYNTH
    a_ins_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ins_cnt_reg != $past(ins_cnt_reg)) |-> ($past(state_reg) == calru_pkg::ST_PWRITE))
        else $error("insert counter moved outside the pending write step");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == calru_pkg::ST_DONE))
        else $error("result raised outside the done step");

    a_pscan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == calru_pkg::ST_PSCAN) |-> (cnt_reg <= CNTW'(PENDING_DEPTH)))
        else $error("pending scan counter ran past the table");

    a_note_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == calru_pkg::ST_DONE) |-> (kind_reg != calru_pkg::KIND_NOTE))
        else $error("note reached the result step");
`endif

endmodule

FILE: sim/client_activity_lru_table_core_tb.sv
// testbench for the client activity lru table core: directed table plus random beats vs predictor
`timescale 1ns / 1ps

module client_activity_lru_table_core_tb;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] req;
        logic [15:0] client;
        logic [7:0]  method;
        logic [47:0] now;
    } beat_in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] client;
        logic [7:0]  method;
        logic [47:0] age;
    } beat_out_t;

    typedef struct {
        beat_in_t  stim;
        logic      typed;
        beat_out_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // predictor state
    logic        pend_valid [calru_pkg::PENDING_DEPTH];
    logic [15:0] pend_req [calru_pkg::PENDING_DEPTH];
    logic [15:0] pend_client [calru_pkg::PENDING_DEPTH];
    logic [31:0] pend_stamp [calru_pkg::PENDING_DEPTH];
    logic [31:0] insert_count;
    logic        slot_valid [calru_pkg::CLIENT_SLOTS];
    logic [15:0] slot_client [calru_pkg::CLIENT_SLOTS];
    logic [7:0]  slot_method [calru_pkg::CLIENT_SLOTS];
    logic [47:0] slot_seen [calru_pkg::CLIENT_SLOTS];

    beat_out_t expected_q[$];
    logic      typed_q[$];
    int        mismatches;
    int        errors;
    bit        no_idle;
    bit        hold_off;
    int        hold_cycles;
    row_t      rows[$];

    client_activity_lru_table_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void note_pending(input logic [15:0] req, input logic [15:0] client);
        int slot;
        logic [31:0] best;
        slot = -1;
        best = 0;
        if (req == 0 || client == 0)
            return;
        for (int i = 0; i < calru_pkg::PENDING_DEPTH; i++)
        begin
            if (pend_valid[i] && pend_req[i] == req)
            begin
                pend_client[i] = client;
                return;
            end
        end
        for (int i = 0; i < calru_pkg::PENDING_DEPTH; i++)
        begin
            if (!pend_valid[i])
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0)
        begin
            for (int i = 0; i < calru_pkg::PENDING_DEPTH; i++)
            begin
                if (slot < 0 || insert_count - pend_stamp[i] > best)
                begin
                    slot = i;
                    best = insert_count - pend_stamp[i];
                end
            end
        end
        pend_valid[slot] = 1'b1;
        pend_req[slot] = req;
        pend_client[slot] = client;
        pend_stamp[slot] = insert_count;
        insert_count++;
    endfunction

    function automatic void touch_client(input logic [15:0] client, input logic [7:0] method,
                                         input logic [47:0] now);
        int slot;
        slot = -1;
        for (int i = 0; i < calru_pkg::CLIENT_SLOTS; i++)
        begin
            if (slot_valid[i] && slot_client[i] == client)
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0)
        begin
            for (int i = 0; i < calru_pkg::CLIENT_SLOTS; i++)
            begin
                if (!slot_valid[i])
                begin
                    slot = i;
                    break;
                end
            end
        end
        if (slot < 0)
        begin
            for (int i = 0; i < calru_pkg::CLIENT_SLOTS; i++)
            begin
                if (slot < 0 || slot_seen[i] < slot_seen[slot])
                    slot = i;
            end
            if (now < slot_seen[slot])
                return;
        end
        slot_valid[slot] = 1'b1;
        slot_client[slot] = client;
        slot_method[slot] = method;
        slot_seen[slot] = now;
    endfunction

    // returns 1 when the beat produces a result
    function automatic bit predict_activity(input beat_in_t b, output beat_out_t r);
        int best;
        logic [15:0] caller;
        r = '0;
        best = -1;
        caller = 0;
        case (b.kind)
            calru_pkg::KIND_NOTE:
            begin
                note_pending(b.req, b.client);
                return 0;
            end
            calru_pkg::KIND_DISPATCH:
            begin
                for (int i = 0; i < calru_pkg::PENDING_DEPTH; i++)
                begin
                    if (pend_valid[i] && pend_req[i] == b.req)
                    begin
                        caller = pend_client[i];
                        pend_valid[i] = 1'b0;
                        r.found = 1'b1;
                        break;
                    end
                end
                touch_client(caller, b.method, b.now);
                r.client = caller;
                return 1;
            end
            calru_pkg::KIND_QUERY:
            begin
                for (int i = 0; i < calru_pkg::CLIENT_SLOTS; i++)
                begin
                    if (!slot_valid[i] || slot_client[i] == b.client)
                        continue;
                    if (best < 0 || slot_seen[i] > slot_seen[best])
                        best = i;
                end
                if (best >= 0)
                begin
                    r.found = 1'b1;
                    r.client = slot_client[best];
                    r.method = slot_method[best];
                    r.age = (b.now > slot_seen[best]) ? b.now - slot_seen[best] : '0;
                end
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic send_beat(input beat_in_t b, input bit typed, input beat_out_t want);
        beat_out_t r;
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b.now, b.method, b.client, b.req};
        s_axis_tuser <= b.kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (predict_activity(b, r))
        begin
            expected_q.push_back(typed ? want : r);
            typed_q.push_back(typed);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic beat_in_t mk(input logic [1:0] k, input logic [15:0] q,
                                    input logic [15:0] c, input logic [7:0] m,
                                    input logic [47:0] t);
        beat_in_t b;
        b.kind = k;
        b.req = q;
        b.client = c;
        b.method = m;
        b.now = t;
        return b;
    endfunction

    task automatic add_row(input beat_in_t b, input bit typed, input beat_out_t want);
        row_t row;
        row.stim = b;
        row.typed = typed;
        row.want = want;
        rows.push_back(row);
    endtask

    function automatic beat_in_t random_beat(input int phase);
        beat_in_t b;
        int pick;
        b.kind = 2'($urandom);
        b.req = 16'($urandom);
        b.client = 16'($urandom);
        b.method = 8'($urandom);
        b.now = {16'($urandom), $urandom};
        pick = $urandom_range(0, 99);
        // mostly small tag pools so notes, dispatches and queries hit each other
        if (pick < 92)
        begin
            b.kind = (pick < 40) ? calru_pkg::KIND_NOTE :
                     (pick < 75) ? calru_pkg::KIND_DISPATCH : calru_pkg::KIND_QUERY;
            if (phase == 0)
            begin
                b.req = 16'($urandom_range(1, 40));
                b.client = 16'($urandom_range(1, 50));
            end
            else
            begin
                b.req = 16'($urandom_range(1, 600));
                b.client = 16'($urandom_range(0, 70));
            end
            if ($urandom_range(0, 9) == 0)
                b.client = 16'($urandom);
            if ($urandom_range(0, 3) != 0)
                b.now = 48'h1000 + 48'($urandom_range(0, 100000));
        end
        else if (pick < 96)
            b.kind = calru_pkg::KIND_UNUSED;
        return b;
    endfunction

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off)
        begin
            hold_cycles <= 3000;
            m_axis_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            hold_cycles <= $urandom_range(1, 15);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        beat_out_t got;
        beat_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.found = m_axis_tuser[0];
            got.client = m_axis_tdata[15:0];
            got.method = m_axis_tdata[23:16];
            got.age = m_axis_tdata[71:24];
            if (expected_q.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected beat %h", got);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                void'(typed_q.pop_front());
                if (got !== want)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: expected found %b client %h method %h age %h, "
                                 , want.found, want.client, want.method, want.age,
                                 "got found %b client %h method %h age %h",
                                 got.found, got.client, got.method, got.age);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #400ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        beat_out_t none;
        beat_in_t b;
        beat_out_t scratch;
        int sent;
        none = '0;
        mismatches = 0;
        errors = 0;
        no_idle = 0;
        hold_off = 0;
        hold_cycles = 0;
        insert_count = 0;
        for (int i = 0; i < calru_pkg::PENDING_DEPTH; i++)
        begin
            pend_valid[i] = 0;
            pend_req[i] = 0;
            pend_client[i] = 0;
            pend_stamp[i] = 0;
        end
        for (int i = 0; i < calru_pkg::CLIENT_SLOTS; i++)
        begin
            slot_valid[i] = 0;
            slot_client[i] = 0;
            slot_method[i] = 0;
            slot_seen[i] = 0;
        end
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: typed results only where obvious
        add_row(mk(calru_pkg::KIND_QUERY, 16'h0, 16'h0, 8'h0, 48'h0), 1, none);
        add_row(mk(calru_pkg::KIND_DISPATCH, 16'h1234, 16'h0, 8'hff, 48'hffffffffffff), 1, none);
        add_row(mk(calru_pkg::KIND_NOTE, 16'h0, 16'h55, 8'h0, 48'h0), 0, none);
        add_row(mk(calru_pkg::KIND_NOTE, 16'h77, 16'h0, 8'h0, 48'h0), 0, none);
        add_row(mk(calru_pkg::KIND_NOTE, 16'hffff, 16'hffff, 8'hff, 48'h0), 0, none);
        add_row(mk(calru_pkg::KIND_NOTE, 16'hffff, 16'h0001, 8'h00, 48'h0), 0, none);
        add_row(mk(calru_pkg::KIND_NOTE, 16'h0001, 16'haaaa, 8'h00, 48'h0), 0, none);
        add_row(mk(calru_pkg::KIND_UNUSED, 16'h0001, 16'h5555, 8'h5a, 48'h5), 0, none);
        add_row(mk(calru_pkg::KIND_DISPATCH, 16'hffff, 16'h0, 8'h00, 48'h100), 0, none);
        add_row(mk(calru_pkg::KIND_DISPATCH, 16'h0001, 16'h0, 8'hff, 48'h200), 0, none);
        add_row(mk(calru_pkg::KIND_DISPATCH, 16'h0001, 16'h0, 8'h3c, 48'h300), 0, none);
        add_row(mk(calru_pkg::KIND_QUERY, 16'h0, 16'h0001, 8'h0, 48'h400), 0, none);
        add_row(mk(calru_pkg::KIND_QUERY, 16'h0, 16'haaaa, 8'h0, 48'h0), 0, none);
        add_row(mk(calru_pkg::KIND_QUERY, 16'h0, 16'h0, 8'h0, 48'hffffffffffff), 0, none);
        add_row(mk(calru_pkg::KIND_NOTE, 16'h0002, 16'h0009, 8'h0, 48'h0), 0, none);
        add_row(mk(calru_pkg::KIND_DISPATCH, 16'h0002, 16'h0, 8'h11, 48'h300), 0, none);
        add_row(mk(calru_pkg::KIND_QUERY, 16'h0, 16'hffff, 8'h0, 48'h300), 0, none);
        foreach (rows[i])
            send_beat(rows[i].stim, rows[i].typed, rows[i].want);
        drain_results();

        // pending table overflow and client table eviction
        for (int i = 0; i < calru_pkg::PENDING_DEPTH + 20; i++)
            send_beat(mk(calru_pkg::KIND_NOTE, 16'(i + 100), 16'(i % 45 + 1), 8'h0, 48'h0),
                      0, none);
        for (int i = 0; i < 60; i++)
        begin
            b = mk(calru_pkg::KIND_DISPATCH, 16'(i * 7 + 95), 16'h0, 8'(i), 48'(i * 3 % 50));
            send_beat(b, 0, none);
        end
        send_beat(mk(calru_pkg::KIND_DISPATCH, 16'h0, 16'h0, 8'h1, 48'h0), 0, none);
        send_beat(mk(calru_pkg::KIND_QUERY, 16'h0, 16'h0, 8'h0, 48'h10), 0, none);

        // long receiver hold-off while beats keep coming
        s_axis_tvalid <= 1'b0;
        hold_off = 1;
        wait (hold_cycles > 15);
        hold_off = 0;
        for (int i = 0; i < 8; i++)
            send_beat(mk(calru_pkg::KIND_QUERY, 16'h0, 16'(i), 8'h0, 48'(i * 1000)), 0, none);
        drain_results();

        sent = 0;
        while (sent < 1300)
        begin
            if (sent > 1150)
                no_idle = 1;
            b = random_beat(sent / 650);
            send_beat(b, 0, none);
            if (b.kind != calru_pkg::KIND_UNUSED &&
                !(b.kind == calru_pkg::KIND_NOTE && (b.req == 0 || b.client == 0)))
                sent++;
        end
        drain_results();
        repeat (calru_pkg::PENDING_DEPTH + calru_pkg::CLIENT_SLOTS + 50) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/calru_pkg.sv
src/client_activity_lru_table_core.sv
sim/client_activity_lru_table_core_tb.sv
